[hdl/stt_pkg.sv]
// Package for the source text tokenizer: word types, scan modes, character codes and helpers.
package stt_pkg;

  localparam int LineBits  = 20;
  localparam int MaxRes    = 6;
  localparam int ResAw     = $clog2(MaxRes + 1);
  localparam int FifoDepth = 8;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChEq     = 8'h3d;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChLBrack = 8'h5b;
  localparam logic [7:0] ChRBrack = 8'h5d;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5c;

  typedef enum logic [2:0] {
    KindNum   = 3'd0,
    KindIdent = 3'd1,
    KindStr   = 3'd2,
    KindChar  = 3'd3,
    KindEnd   = 3'd4,
    KindSym   = 3'd5
  } tok_kind_e;

  typedef enum logic [3:0] {
    ModeIdle     = 4'd0,
    ModeNum      = 4'd1,
    ModeNumDot   = 4'd2,
    ModeIdent    = 4'd3,
    ModeComment  = 4'd4,
    ModeStr      = 4'd5,
    ModeStrEsc   = 4'd6,
    ModeCharVal  = 4'd7,
    ModeCharSkip = 4'd8,
    ModeCr       = 4'd9,
    ModeSym1     = 4'd10,
    ModeSym2     = 4'd11
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    tok_kind_e             token_kind;
    logic                  is_close;
    logic [7:0]            out_byte;
    logic [LineBits-1:0]   line_number;
    logic                  bad_string;
    logic                  last_of_run;
  } out_word_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  endfunction

  function automatic logic is_identc(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == ChUnder);
  endfunction

  // Builds one result word; close markers always carry a zero byte.
  function automatic out_word_t mk_res(tok_kind_e k, logic cl, logic [7:0] by, logic bad,
                                       logic [LineBits-1:0] ln);
    out_word_t r;
    r.token_kind  = k;
    r.is_close    = cl;
    r.out_byte    = cl ? 8'h00 : by;
    r.line_number = ln;
    r.bad_string  = bad;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

[hdl/source_text_tokenizer_unit.sv]
// Top level of the source text tokenizer: input register, scan logic and result queue.
//
//   Channel | Direction | Handshake                 | Word
//   --------+-----------+---------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o   | stt_pkg::in_word_t  (byte, end)
//   out     | output    | out_valid_o / out_stall_i | stt_pkg::out_word_t (one token char)
//
// An accepted input word waits in the input register for queue room, is scanned by a
// single layer of combinational logic, and its zero to five result words are pushed
// into an eight-entry result queue in that same cycle. The result port drains the
// queue one word per cycle, so the rate is one input word per cycle as long as the
// output keeps up; a word that yields n results hands them over one after another.
// The input register holds its word (and stalls the input) while the queue has
// fewer than six free entries. Reset is asynchronous and returns the scanner to
// its idle mode with the line counter at one; no clearing pass is needed.
module source_text_tokenizer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  stt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output stt_pkg::out_word_t out_word_o
);
  import stt_pkg::*;

  // Input register.
  in_word_t in_q;
  logic     in_valid_q, in_valid_d;
  logic     in_accept, proc_go;

  // Scanner state.
  scan_mode_e          mode_q, mode_d;
  logic [7:0]          held_q, held_d;
  logic [7:0]          held2_q, held2_d;
  logic [LineBits-1:0] line_q, line_d;

  // Result queue.
  out_word_t         fifo_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q, count_d;
  logic              pop;

  // Results of the current word.
  out_word_t        res [MaxRes];
  logic [ResAw-1:0] rn;

  logic       do_sym, do_idle, do_lend, do_str, pair;
  logic [7:0] b, sym_c;

  // The queue must have room for the worst-case burst before a word is scanned.
  assign proc_go    = in_valid_q && (count_q <= (FifoAw+1)'(FifoDepth - MaxRes));
  assign in_stall_o = in_valid_q && !proc_go;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept ? 1'b1 : (proc_go ? 1'b0 : in_valid_q);

  assign out_valid_o = (count_q != '0);
  assign out_word_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Scan logic. Results are appended in the order the token rules produce them;
  // the symbol lookahead and the idle classification may both follow the mode step,
  // and a line end is always the final pair of results.
  always_comb begin
    mode_d  = mode_q;
    held_d  = held_q;
    held2_d = held2_q;
    line_d  = line_q;
    rn      = '0;
    do_sym  = 1'b0;
    do_idle = 1'b0;
    do_lend = 1'b0;
    do_str  = 1'b0;
    pair    = 1'b0;
    sym_c   = held_q;
    b       = in_q.text_byte;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '0;
    end

    if (in_q.end_of_text) begin
      // Flush whatever token is open, then close the text with a line end.
      case (mode_q)
        ModeNum: begin
          res[rn] = mk_res(KindNum, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
        end
        ModeIdent: begin
          res[rn] = mk_res(KindIdent, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
        end
        ModeNumDot: begin
          res[rn] = mk_res(KindNum, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
          res[rn] = mk_res(KindSym, 1'b0, ChDot, 1'b0, line_q); rn = rn + 1'b1;
          res[rn] = mk_res(KindSym, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
        end
        ModeCr, ModeSym1: begin
          res[rn] = mk_res(KindSym, 1'b0, held_q, 1'b0, line_q); rn = rn + 1'b1;
          res[rn] = mk_res(KindSym, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
        end
        ModeSym2: begin
          res[rn] = mk_res(KindSym, 1'b0, held_q, 1'b0, line_q); rn = rn + 1'b1;
          res[rn] = mk_res(KindSym, 1'b0, held2_q, 1'b0, line_q); rn = rn + 1'b1;
          res[rn] = mk_res(KindSym, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
        end
        ModeStr, ModeStrEsc: begin
          res[rn] = mk_res(KindStr, 1'b1, 8'h00, 1'b1, line_q); rn = rn + 1'b1;
        end
        default: begin
        end
      endcase
      do_lend = 1'b1;
    end else begin
      case (mode_q)
        ModeNum: begin
          if (is_digit(b)) begin
            res[rn] = mk_res(KindNum, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
          end else if (b == ChDot) begin
            held_d = b;
            mode_d = ModeNumDot;
          end else begin
            res[rn] = mk_res(KindNum, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
            do_idle = 1'b1;
          end
        end
        ModeNumDot: begin
          if (is_digit(b)) begin
            res[rn] = mk_res(KindNum, 1'b0, ChDot, 1'b0, line_q); rn = rn + 1'b1;
            res[rn] = mk_res(KindNum, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
            mode_d = ModeNum;
          end else begin
            res[rn] = mk_res(KindNum, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
            do_sym = 1'b1;
            sym_c  = ChDot;
          end
        end
        ModeIdent: begin
          if (is_identc(b)) begin
            res[rn] = mk_res(KindIdent, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
          end else begin
            res[rn] = mk_res(KindIdent, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
            do_idle = 1'b1;
          end
        end
        ModeComment: begin
          if (b == ChLf) begin
            do_idle = 1'b1;
          end
        end
        ModeStr: begin
          do_str = 1'b1;
        end
        ModeStrEsc: begin
          // An escaped quote stays in the string as a plain character.
          if (b == ChDquote) begin
            res[rn] = mk_res(KindStr, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
            mode_d = ModeStr;
          end else begin
            do_str = 1'b1;
          end
        end
        ModeCharVal: begin
          res[rn] = mk_res(KindChar, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
          res[rn] = mk_res(KindChar, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
          mode_d = ModeCharSkip;
        end
        ModeCharSkip: begin
          mode_d = ModeIdle;
        end
        ModeCr: begin
          if (b == ChLf) begin
            do_lend = 1'b1;
            mode_d  = ModeIdle;
          end else begin
            do_sym = 1'b1;
          end
        end
        ModeSym1: begin
          do_sym = 1'b1;
        end
        ModeSym2: begin
          res[rn] = mk_res(KindSym, 1'b0, held_q, 1'b0, line_q); rn = rn + 1'b1;
          res[rn] = mk_res(KindSym, 1'b0, held2_q, 1'b0, line_q); rn = rn + 1'b1;
          if (b == ChDot) begin
            res[rn] = mk_res(KindSym, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
            res[rn] = mk_res(KindSym, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
            mode_d = ModeIdle;
          end else begin
            res[rn] = mk_res(KindSym, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
            do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    // Byte inside a string literal.
    if (do_str) begin
      if (b == ChDquote) begin
        res[rn] = mk_res(KindStr, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
        mode_d = ModeIdle;
      end else begin
        res[rn] = mk_res(KindStr, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
        mode_d = (b == ChBslash) ? ModeStrEsc : ModeStr;
      end
    end

    // Resolve a held symbol byte against the lookahead byte.
    if (do_sym) begin
      pair = (b == ChEq) || ((sym_c == ChColon) && (b == ChColon)) ||
             ((sym_c == ChLBrack) && (b == ChRBrack)) ||
             ((sym_c == ChPlus) && (b == ChPlus)) ||
             ((sym_c == ChMinus) && (b == ChMinus)) ||
             ((sym_c == ChDot) && (b == ChDot));
      if ((sym_c == ChDot) && (b == ChDot)) begin
        held_d  = ChDot;
        held2_d = ChDot;
        mode_d  = ModeSym2;
      end else if (pair) begin
        res[rn] = mk_res(KindSym, 1'b0, sym_c, 1'b0, line_q); rn = rn + 1'b1;
        res[rn] = mk_res(KindSym, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
        res[rn] = mk_res(KindSym, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
        mode_d = ModeIdle;
      end else begin
        res[rn] = mk_res(KindSym, 1'b0, sym_c, 1'b0, line_q); rn = rn + 1'b1;
        res[rn] = mk_res(KindSym, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
        do_idle = 1'b1;
      end
    end

    // Classify a byte seen between tokens.
    if (do_idle) begin
      mode_d = ModeIdle;
      if (is_digit(b)) begin
        res[rn] = mk_res(KindNum, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
        mode_d = ModeNum;
      end else if ((b == ChUnder) || is_alpha(b)) begin
        res[rn] = mk_res(KindIdent, 1'b0, b, 1'b0, line_q); rn = rn + 1'b1;
        mode_d = ModeIdent;
      end else if ((b == ChSpace) || (b == ChTab)) begin
        mode_d = ModeIdle;
      end else if (b == ChHash) begin
        mode_d = ModeComment;
      end else if (b == ChDquote) begin
        mode_d = ModeStr;
      end else if (b == ChSquote) begin
        mode_d = ModeCharVal;
      end else if (b == ChLf) begin
        do_lend = 1'b1;
      end else if (b == ChCr) begin
        held_d = b;
        mode_d = ModeCr;
      end else begin
        held_d = b;
        mode_d = ModeSym1;
      end
    end

    // Line end token; the counter saturates at its all-ones value.
    if (do_lend) begin
      res[rn] = mk_res(KindEnd, 1'b0, ChSemi, 1'b0, line_q); rn = rn + 1'b1;
      res[rn] = mk_res(KindEnd, 1'b1, 8'h00, 1'b0, line_q); rn = rn + 1'b1;
      if (line_q != '1) begin
        line_d = line_q + 1'b1;
      end
    end

    // End of text leaves the scanner as after reset, ready for the next text.
    if (in_q.end_of_text) begin
      mode_d  = ModeIdle;
      held_d  = 8'h00;
      held2_d = 8'h00;
      line_d  = LineBits'(1);
    end

    for (int i = 0; i < MaxRes; i++) begin
      if (ResAw'(i) == rn - 1'b1) begin
        res[i].last_of_run = 1'b1;
      end
    end
  end

  always_comb begin
    count_d = count_q - (FifoAw+1)'(pop);
    if (proc_go) begin
      count_d = count_d + (FifoAw+1)'(rn);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= ModeIdle;
      held_q     <= 8'h00;
      held2_q    <= 8'h00;
      line_q     <= LineBits'(1);
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      count_q    <= count_d;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (proc_go) begin
        mode_q   <= mode_d;
        held_q   <= held_d;
        held2_q  <= held2_d;
        line_q   <= line_d;
        wr_ptr_q <= wr_ptr_q + FifoAw'(rn);
      end
    end
  end

  // Payload storage: input register and queue entries need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_word_i;
    end
    if (proc_go) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (ResAw'(i) < rn) begin
          fifo_q[wr_ptr_q + FifoAw'(i)] <= res[i];
        end
      end
    end
  end

endmodule

[hdl/stt_checker.sv]
// Port-level checker for the source text tokenizer, bound to the top level.
module stt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input stt_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input stt_pkg::out_word_t out_word_o
);
  import stt_pkg::*;

  logic in_seen;
  assign in_seen = in_valid_i && !in_stall_o && in_word_i.end_of_text;

  // A stalled result word must stay put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.is_close |-> out_word_o.out_byte == 8'h00)
    else $error("close marker carries a nonzero byte");

  a_bad_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.bad_string |->
      out_word_o.is_close && out_word_o.token_kind == KindStr)
    else $error("bad string flag outside a string close marker");

  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.token_kind == KindEnd && !out_word_o.is_close |->
      out_word_o.out_byte == ChSemi)
    else $error("line end token with a byte other than semicolon");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o || in_seen |-> !out_valid_o || out_word_o.line_number != '0)
    else $error("result word on line zero");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the source text tokenizer: directed table, random text, predictor.
module testbench;

  import stt_pkg::*;

  // Number of counted random text words, and the run limit in ns.
  localparam int RandWords = 170;
  localparam int RunLimitNs = 1000000;
  localparam int DrainCycles = 24;

  // One row of the directed table. When n_typed is nonzero the expected result
  // words are written out in the row itself, otherwise the predictor supplies them.
  typedef struct packed {
    in_word_t        word;
    logic [1:0]      n_typed;
    out_word_t [2:0] typed;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;

  source_text_tokenizer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // 2 ns clock: one delay for the high half, one for the low half.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Token predictor. It keeps its own copy of the scanner state and turns one
  // input word into the list of result words that word should produce.
  // ------------------------------------------------------------------------
  scan_mode_e           tk_mode;
  logic [7:0]           tk_held;
  logic [7:0]           tk_held_two;
  logic [LineBits-1:0]  tk_line;

  out_word_t token_q[$];   // result words still owed by the DUT, oldest first
  out_word_t burst_q[$];   // result words of the word being predicted

  int n_fail = 0;

  function automatic logic dec_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic letter(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic void tk_reset();
    tk_mode     = ModeIdle;
    tk_held     = 8'h00;
    tk_held_two = 8'h00;
    tk_line     = LineBits'(1);
  endfunction

  // Appends one result word, tagged with the current line. A word never
  // yields more than MaxRes results.
  function automatic void emit(tok_kind_e k, logic cl, logic [7:0] by, logic bad);
    out_word_t r;
    if (burst_q.size() < MaxRes) begin
      r.token_kind  = k;
      r.is_close    = cl;
      r.out_byte    = cl ? 8'h00 : by;
      r.line_number = tk_line;
      r.bad_string  = bad;
      r.last_of_run = 1'b0;
      burst_q = {burst_q, r};
    end
  endfunction

  // The ";" token and its close carry the current line, then the counter
  // advances and sticks at its maximum.
  function automatic void line_break();
    emit(KindEnd, 1'b0, ChSemi, 1'b0);
    emit(KindEnd, 1'b1, 8'h00, 1'b0);
    if (tk_line != {LineBits{1'b1}}) tk_line = tk_line + 1'b1;
  endfunction

  // A byte seen between tokens opens a new token or is held for lookahead.
  function automatic void enter_idle(logic [7:0] b);
    tk_mode = ModeIdle;
    if (dec_digit(b)) begin
      emit(KindNum, 1'b0, b, 1'b0);
      tk_mode = ModeNum;
    end else if (b == ChUnder || letter(b)) begin
      emit(KindIdent, 1'b0, b, 1'b0);
      tk_mode = ModeIdent;
    end else if (b == ChSpace || b == ChTab) begin
      tk_mode = ModeIdle;
    end else if (b == ChHash) begin
      tk_mode = ModeComment;
    end else if (b == ChDquote) begin
      tk_mode = ModeStr;
    end else if (b == ChSquote) begin
      tk_mode = ModeCharVal;
    end else if (b == ChLf) begin
      line_break();
    end else if (b == ChCr) begin
      tk_held = b;
      tk_mode = ModeCr;
    end else begin
      tk_held = b;
      tk_mode = ModeSym1;
    end
  endfunction

  // Resolves held symbol byte c against lookahead byte b.
  function automatic void resolve_sym(logic [7:0] c, logic [7:0] b);
    logic pair;
    pair = (b == ChEq) || (c == ChColon && b == ChColon) ||
           (c == ChLBrack && b == ChRBrack) || (c == ChPlus && b == ChPlus) ||
           (c == ChMinus && b == ChMinus) || (c == ChDot && b == ChDot);
    if (c == ChDot && b == ChDot) begin
      tk_held     = ChDot;
      tk_held_two = ChDot;
      tk_mode     = ModeSym2;
    end else if (pair) begin
      emit(KindSym, 1'b0, c, 1'b0);
      emit(KindSym, 1'b0, b, 1'b0);
      emit(KindSym, 1'b1, 8'h00, 1'b0);
      tk_mode = ModeIdle;
    end else begin
      emit(KindSym, 1'b0, c, 1'b0);
      emit(KindSym, 1'b1, 8'h00, 1'b0);
      enter_idle(b);
    end
  endfunction

  function automatic void string_char(logic [7:0] b);
    if (b == ChDquote) begin
      emit(KindStr, 1'b1, 8'h00, 1'b0);
      tk_mode = ModeIdle;
    end else if (b == ChBslash) begin
      emit(KindStr, 1'b0, b, 1'b0);
      tk_mode = ModeStrEsc;
    end else begin
      emit(KindStr, 1'b0, b, 1'b0);
      tk_mode = ModeStr;
    end
  endfunction

  // End of text: close whatever is open, then the final line end.
  function automatic void flush_text();
    case (tk_mode)
      ModeNum: emit(KindNum, 1'b1, 8'h00, 1'b0);
      ModeIdent: emit(KindIdent, 1'b1, 8'h00, 1'b0);
      ModeNumDot: begin
        emit(KindNum, 1'b1, 8'h00, 1'b0);
        emit(KindSym, 1'b0, ChDot, 1'b0);
        emit(KindSym, 1'b1, 8'h00, 1'b0);
      end
      ModeCr, ModeSym1: begin
        emit(KindSym, 1'b0, tk_held, 1'b0);
        emit(KindSym, 1'b1, 8'h00, 1'b0);
      end
      ModeSym2: begin
        emit(KindSym, 1'b0, tk_held, 1'b0);
        emit(KindSym, 1'b0, tk_held_two, 1'b0);
        emit(KindSym, 1'b1, 8'h00, 1'b0);
      end
      ModeStr, ModeStrEsc: emit(KindStr, 1'b1, 8'h00, 1'b1);
      default: begin
      end
    endcase
    line_break();
  endfunction

  // Predicts the result words of one accepted input word into burst_q.
  function automatic void tokenize_word(in_word_t w);
    logic [7:0] b;
    out_word_t  tail;
    b = w.text_byte;
    burst_q.delete();
    if (w.end_of_text) begin
      flush_text();
      tk_reset();
    end else begin
      case (tk_mode)
        ModeNum: begin
          if (dec_digit(b)) begin
            emit(KindNum, 1'b0, b, 1'b0);
          end else if (b == ChDot) begin
            tk_held = b;
            tk_mode = ModeNumDot;
          end else begin
            emit(KindNum, 1'b1, 8'h00, 1'b0);
            enter_idle(b);
          end
        end
        ModeNumDot: begin
          if (dec_digit(b)) begin
            emit(KindNum, 1'b0, ChDot, 1'b0);
            emit(KindNum, 1'b0, b, 1'b0);
            tk_mode = ModeNum;
          end else begin
            emit(KindNum, 1'b1, 8'h00, 1'b0);
            resolve_sym(ChDot, b);
          end
        end
        ModeIdent: begin
          if (letter(b) || dec_digit(b) || b == ChUnder) begin
            emit(KindIdent, 1'b0, b, 1'b0);
          end else begin
            emit(KindIdent, 1'b1, 8'h00, 1'b0);
            enter_idle(b);
          end
        end
        ModeComment: begin
          if (b == ChLf) enter_idle(b);
        end
        ModeStr: string_char(b);
        ModeStrEsc: begin
          // A quote right after a backslash stays inside the string.
          if (b == ChDquote) begin
            emit(KindStr, 1'b0, b, 1'b0);
            tk_mode = ModeStr;
          end else begin
            string_char(b);
          end
        end
        ModeCharVal: begin
          emit(KindChar, 1'b0, b, 1'b0);
          emit(KindChar, 1'b1, 8'h00, 1'b0);
          tk_mode = ModeCharSkip;
        end
        ModeCharSkip: tk_mode = ModeIdle;
        ModeCr: begin
          if (b == ChLf) begin
            line_break();
            tk_mode = ModeIdle;
          end else begin
            resolve_sym(tk_held, b);
          end
        end
        ModeSym1: resolve_sym(tk_held, b);
        ModeSym2: begin
          emit(KindSym, 1'b0, tk_held, 1'b0);
          emit(KindSym, 1'b0, tk_held_two, 1'b0);
          if (b == ChDot) begin
            emit(KindSym, 1'b0, b, 1'b0);
            emit(KindSym, 1'b1, 8'h00, 1'b0);
            tk_mode = ModeIdle;
          end else begin
            emit(KindSym, 1'b1, 8'h00, 1'b0);
            enter_idle(b);
          end
        end
        default: enter_idle(b);
      endcase
    end
    if (burst_q.size() > 0) begin
      tail = burst_q.pop_back();
      tail.last_of_run = 1'b1;
      burst_q = {burst_q, tail};
    end
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers.
  // ------------------------------------------------------------------------
  function automatic in_word_t text_word(logic [7:0] b);
    in_word_t w;
    w.text_byte   = b;
    w.end_of_text = 1'b0;
    return w;
  endfunction

  // The byte of an end-of-text word is ignored, so it is left random.
  function automatic in_word_t eot_word();
    in_word_t w;
    w.text_byte   = 8'($urandom_range(0, 255));
    w.end_of_text = 1'b1;
    return w;
  endfunction

  function automatic stim_row_t plain_row(in_word_t w);
    stim_row_t r;
    r = '0;
    r.word = w;
    return r;
  endfunction

  function automatic out_word_t tw(tok_kind_e k, logic cl, logic [7:0] by,
                                   logic [LineBits-1:0] ln, logic bad, logic last);
    out_word_t r;
    r.token_kind  = k;
    r.is_close    = cl;
    r.out_byte    = by;
    r.line_number = ln;
    r.bad_string  = bad;
    r.last_of_run = last;
    return r;
  endfunction

  // Row whose results are written out: the bare line end on line one, and
  // optionally an unterminated string close in front of it.
  function automatic stim_row_t line_one_row(in_word_t w, logic with_bad_str);
    stim_row_t r;
    r = plain_row(w);
    if (with_bad_str) begin
      r.n_typed  = 2'd3;
      r.typed[0] = tw(KindStr, 1'b1, 8'h00, LineBits'(1), 1'b1, 1'b0);
      r.typed[1] = tw(KindEnd, 1'b0, ChSemi, LineBits'(1), 1'b0, 1'b0);
      r.typed[2] = tw(KindEnd, 1'b1, 8'h00, LineBits'(1), 1'b0, 1'b1);
    end else begin
      r.n_typed  = 2'd2;
      r.typed[0] = tw(KindEnd, 1'b0, ChSemi, LineBits'(1), 1'b0, 1'b0);
      r.typed[1] = tw(KindEnd, 1'b1, 8'h00, LineBits'(1), 1'b0, 1'b1);
    end
    return r;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_punct();
    string p;
    p = "+-*/<>=!&|:[]().,;{}%^~@$?";
    return p[$urandom_range(0, p.len() - 1)];
  endfunction

  // ------------------------------------------------------------------------
  // Input side: words go out in bursts of random length with random gaps in
  // between. Acceptance is judged at the falling edge, where valid and stall
  // have settled for the coming rising edge.
  // ------------------------------------------------------------------------
  stim_row_t dir_tab[$];
  in_word_t  text_q[$];
  int        counted_words = 0;
  int        burst_left = 0;
  int        gap_len;
  logic      quiet_stretch = 1'b0;

  // Queues one random text word; bytes that only get skipped (whitespace and
  // comment bodies) do not count toward the random total.
  task automatic push_text(logic [7:0] b, int counts);
    text_q = {text_q, text_word(b)};
    if (counts != 0) counted_words++;
  endtask

  task automatic drive_row(stim_row_t r);
    int i;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // Now and then a long stretch runs with no gaps at all.
      if ($urandom_range(0, 7) == 0) quiet_stretch = ~quiet_stretch;
      gap_len = quiet_stretch ? 0 : $urandom_range(0, 6);
      if (gap_len > 0) begin
        @(posedge clk_i);
        in_valid <= 1'b0;
        repeat (gap_len - 1) @(posedge clk_i);
      end
    end
    burst_left--;
    @(posedge clk_i);
    in_valid <= 1'b1;
    in_word  <= r.word;
    do @(negedge clk_i); while (in_stall);
    // The word is taken at the coming rising edge; its results are owed from now on.
    tokenize_word(r.word);
    if (r.n_typed != 0) begin
      for (i = 0; i < r.n_typed; i++) token_q = {token_q, r.typed[i]};
    end else begin
      foreach (burst_q[j]) token_q = {token_q, burst_q[j]};
    end
  endtask

  // Builds one fragment of random source text. Most fragments are well-formed
  // tokens with random content; the rest are noise bytes and cut-off text.
  task automatic make_fragment();
    int pick;
    int k;
    logic [7:0] b;
    pick = $urandom_range(0, 15);
    case (pick)
      0, 1: begin
        // Number, sometimes with a fraction and sometimes with a dangling dot.
        repeat ($urandom_range(1, 4)) push_text(rand_digit(), 1);
        if ($urandom_range(0, 2) == 0) begin
          push_text(ChDot, 1);
          if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 3)) push_text(rand_digit(), 1);
          end
        end
      end
      2, 3, 15: begin
        push_text(($urandom_range(0, 4) == 0) ? ChUnder : rand_letter(), 1);
        repeat ($urandom_range(0, 5)) begin
          k = $urandom_range(0, 2);
          push_text((k == 0) ? rand_letter() : (k == 1) ? rand_digit() : ChUnder, 1);
        end
      end
      4: begin
        // String with escaped quotes, lone backslashes and embedded newlines.
        push_text(ChDquote, 1);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 5))
            0: begin
              push_text(ChBslash, 1);
              push_text(ChDquote, 1);
            end
            1: push_text(ChBslash, 1);
            2: push_text(ChLf, 1);
            default: push_text(8'($urandom_range(8'h20, 8'h7e)), 1);
          endcase
        end
        push_text(ChDquote, 1);
      end
      5: begin
        push_text(ChSquote, 1);
        push_text(8'($urandom_range(0, 255)), 1);
        push_text(ChSquote, 1);
      end
      6: begin
        push_text(ChHash, 1);
        repeat ($urandom_range(0, 4)) begin
          b = 8'($urandom_range(0, 255));
          push_text((b == ChLf) ? ChSpace : b, 0);
        end
        push_text(ChLf, 1);
      end
      7, 8: begin
        case ($urandom_range(0, 7))
          0: begin
            push_text(rand_punct(), 1);
            push_text(ChEq, 1);
          end
          1: begin
            push_text(ChColon, 1);
            push_text(ChColon, 1);
          end
          2: begin
            push_text(ChLBrack, 1);
            push_text(ChRBrack, 1);
          end
          3: begin
            push_text(ChPlus, 1);
            push_text(ChPlus, 1);
          end
          4: begin
            push_text(ChMinus, 1);
            push_text(ChMinus, 1);
          end
          5: begin
            push_text(ChDot, 1);
            push_text(ChDot, 1);
          end
          6: repeat (3) push_text(ChDot, 1);
          default: push_text(rand_punct(), 1);
        endcase
      end
      9: push_text($urandom_range(0, 1) ? ChSpace : ChTab, 0);
      10: push_text(ChLf, 1);
      11: begin
        push_text(ChCr, 1);
        push_text(ChLf, 1);
      end
      12, 13: push_text(8'($urandom_range(0, 255)), 1);
      default: begin
        // End of text, often right after something left open.
        case ($urandom_range(0, 6))
          0: push_text(ChDquote, 1);
          1: push_text(ChSquote, 1);
          2: push_text(ChHash, 1);
          3: push_text(ChPlus, 1);
          4: begin
            push_text(rand_digit(), 1);
            push_text(ChDot, 1);
          end
          5: begin
            push_text(ChDot, 1);
            push_text(ChDot, 1);
          end
          default: begin
          end
        endcase
        text_q = {text_q, eot_word()};
        counted_words++;
      end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // Output side: the receiver switches between stall patterns of its own,
  // including stretches with no stalling at all.
  // ------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_run = 0;
  int stall_tick = 0;

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(4, 40);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= (stall_tick % 8) < 3;
      default: out_stall <= 1'b1;
    endcase
  end

  // Compares one field of a result word and counts a mismatch.
  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Every result word the DUT hands over is matched against the oldest
  // expectation. Sampling at the falling edge keeps clear of the rising edge.
  out_word_t owed;

  always @(negedge clk_i) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (token_q.size() == 0) begin
        $error("result word with nothing expected: kind %0d byte 0x%0h line %0d",
               out_word.token_kind, out_word.out_byte, out_word.line_number);
        n_fail++;
      end else begin
        owed = token_q.pop_front();
        check_field("token_kind", owed.token_kind, out_word.token_kind);
        check_field("is_close", owed.is_close, out_word.is_close);
        check_field("out_byte", owed.out_byte, out_word.out_byte);
        check_field("line_number", owed.line_number, out_word.line_number);
        check_field("bad_string", owed.bad_string, out_word.bad_string);
        check_field("last_of_run", owed.last_of_run, out_word.last_of_run);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence: reset, the directed table, random text, then drain.
  // ------------------------------------------------------------------------
  initial begin
    in_valid = 1'b0;
    in_word  = '0;
    rst_n    = 1'b0;
    tk_reset();

    // End of text straight after reset gives just the line end on line one.
    dir_tab = {dir_tab, line_one_row(eot_word(), 1'b0)};
    // End of text inside an open string closes it with the error flag set.
    dir_tab = {dir_tab, plain_row(text_word(ChDquote))};
    dir_tab = {dir_tab, line_one_row(eot_word(), 1'b1)};
    dir_tab = {dir_tab, line_one_row(text_word(ChLf), 1'b0)};
    // The byte extremes are plain symbols; the top byte pairs with '='.
    dir_tab = {dir_tab, plain_row(text_word(8'h00))};
    dir_tab = {dir_tab, plain_row(text_word(8'hff))};
    dir_tab = {dir_tab, plain_row(text_word(ChEq))};
    // A digit then three dots: the number closes and "..." is one symbol.
    dir_tab = {dir_tab, plain_row(text_word("9"))};
    repeat (3) dir_tab = {dir_tab, plain_row(text_word(ChDot))};
    // Identifier, then a comment whose newline counts as one line.
    dir_tab = {dir_tab, plain_row(text_word(ChUnder))};
    dir_tab = {dir_tab, plain_row(text_word(ChHash))};
    dir_tab = {dir_tab, plain_row(text_word(ChLf))};
    // String holding an escaped quote, then an empty string.
    dir_tab = {dir_tab, plain_row(text_word(ChDquote))};
    dir_tab = {dir_tab, plain_row(text_word(ChBslash))};
    dir_tab = {dir_tab, plain_row(text_word(ChDquote))};
    repeat (3) dir_tab = {dir_tab, plain_row(text_word(ChDquote))};
    // Char literal whose character is a newline, which does not count as a line.
    dir_tab = {dir_tab, plain_row(text_word(ChSquote))};
    dir_tab = {dir_tab, plain_row(text_word(ChLf))};
    dir_tab = {dir_tab, plain_row(text_word(ChSquote))};
    // A lone CR is a symbol; CR LF is a line end.
    dir_tab = {dir_tab, plain_row(text_word(ChCr))};
    dir_tab = {dir_tab, plain_row(text_word("a"))};
    dir_tab = {dir_tab, plain_row(text_word(ChCr))};
    dir_tab = {dir_tab, plain_row(text_word(ChLf))};
    dir_tab = {dir_tab, plain_row(eot_word())};

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) drive_row(dir_tab[i]);

    while (counted_words < RandWords) begin
      make_fragment();
      while (text_q.size() != 0) drive_row(plain_row(text_q.pop_front()));
    end
    @(posedge clk_i);
    in_valid <= 1'b0;

    // Let every owed result word arrive, then give stray words time to show up.
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RunLimitNs);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
